### design/gdr_pkg.sv
// shared types, widths and constants of the grid dda column raycaster
package gdr_pkg;

   // defaults of the top level parameters
   localparam int GRID_SIZE_DEF  = 16;
   localparam int STEP_LIMIT_DEF = 32;

   // payload and register widths
   localparam int COL_W       = 12;
   localparam int ROW_W       = 12;
   localparam int CELL_W      = 4;
   localparam int POS_W       = 16;
   localparam int VEC_W       = 16;
   localparam int DIST_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // fixed point layout
   localparam int FRAC_W     = 12;   // fraction bits of a position
   localparam int VEC_FRAC_W = 14;   // fraction bits of a vector

   // internal datapath widths
   localparam int CX_W      = 29;    // camera space offset, signed
   localparam int PROD_W    = 45;    // plane times offset, signed
   localparam int RAY_W     = 18;    // saturated ray component, signed
   localparam int DELTA_W   = 31;    // per cell side distance step
   localparam int SIDE_W    = 40;    // accumulated side distance
   localparam int COORD_W   = 8;     // map coordinate during the walk, signed
   localparam int NUM_W     = 22;    // offset to the struck grid line, signed
   localparam int HGT_W     = 20;    // line height
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_BITS  = 4;     // quotient bits per divider cycle

   localparam int QUEUE_DEPTH = 2;

   // input item kinds
   localparam logic KIND_CELL_WRITE = 1'b0;
   localparam logic KIND_CAST       = 1'b1;

   // hit side codes
   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAM_POS_X   = 3'd0,
      CSR_CAM_POS_Y   = 3'd1,
      CSR_VIEW_DIR_X  = 3'd2,
      CSR_VIEW_DIR_Y  = 3'd3,
      CSR_CAM_PLANE_X = 3'd4,
      CSR_CAM_PLANE_Y = 3'd5,
      CSR_SCREEN_COLS = 3'd6,
      CSR_SCREEN_ROWS = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [POS_W-1:0]        CAM_POS_X_RST   = 16'd20480;
   localparam logic [POS_W-1:0]        CAM_POS_Y_RST   = 16'd20480;
   localparam logic signed [VEC_W-1:0] VIEW_DIR_X_RST  = -16'sd16384;
   localparam logic signed [VEC_W-1:0] VIEW_DIR_Y_RST  = 16'sd164;
   localparam logic signed [VEC_W-1:0] CAM_PLANE_X_RST = 16'sd1638;
   localparam logic signed [VEC_W-1:0] CAM_PLANE_Y_RST = 16'sd10813;
   localparam logic [COL_W-1:0]        SCREEN_COLS_RST = 12'd800;
   localparam logic [ROW_W-1:0]        SCREEN_ROWS_RST = 12'd600;

   typedef struct packed {
      logic              kind;
      logic [COL_W-1:0]  column;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              cell_wall;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  span_top;
      logic [ROW_W-1:0]  span_bottom;
      logic              hit_side;
      logic [CELL_W-1:0] hit_cell_x;
      logic [CELL_W-1:0] hit_cell_y;
      logic [DIST_W-1:0] wall_distance;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]        cam_pos_x;
      logic [POS_W-1:0]        cam_pos_y;
      logic signed [VEC_W-1:0] view_dir_x;
      logic signed [VEC_W-1:0] view_dir_y;
      logic signed [VEC_W-1:0] cam_plane_x;
      logic signed [VEC_W-1:0] cam_plane_y;
      logic [COL_W-1:0]        screen_cols;
      logic [ROW_W-1:0]        screen_rows;
   } cfg_type;

   // classified item between front and back end
   typedef struct packed {
      logic              is_cast;
      logic [COL_W-1:0]  column;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              cell_wall;
   } cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

### design/gdr_ram.sv
// generic single write port ram with registered read
module gdr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gdr_div.sv
// iterative unsigned restoring divider, a few quotient bits per cycle
module gdr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gdr_pkg::div_req_type req,
   output gdr_pkg::div_rsp_type rsp
);

   localparam int NW    = gdr_pkg::DIV_NUM_W;
   localparam int DW    = gdr_pkg::DIV_DEN_W;
   localparam int STEPS = NW / gdr_pkg::DIV_BITS;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]      rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    den_ff, den_in;

   always_comb begin
      logic [DW:0]   rem_t;
      logic [NW-1:0] quo_t;
      rem_t   = rem_ff;
      quo_t   = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      for (int i = 0; i < gdr_pkg::DIV_BITS; i++) begin
         rem_t = {rem_t[DW-1:0], quo_t[NW-1]};
         quo_t = {quo_t[NW-2:0], 1'b0};
         if (rem_t >= {1'b0, den_ff}) begin
            rem_t    = rem_t - {1'b0, den_ff};
            quo_t[0] = 1'b1;
         end
      end
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = rem_t;
         quo_in = quo_t;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

### design/gdr_queue.sv
// short command queue between front and back end
module gdr_queue #(
   parameter int DEPTH = gdr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gdr_pkg::cmd_type push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output gdr_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gdr_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/gdr_front.sv
// front end: accepts input items, drops off-grid cell writes, queues the rest
module gdr_front #(
   parameter int GRID_SIZE = gdr_pkg::GRID_SIZE_DEF
) (
   input  logic             req_valid,
   output logic             req_ready,
   input  gdr_pkg::req_type req_data,
   output logic             cmd_push,
   output gdr_pkg::cmd_type cmd_data,
   input  logic             cmd_ready
);

   localparam int CW = gdr_pkg::COORD_W;

   logic in_grid;
   logic keep;

   assign in_grid = (CW'(req_data.cell_x) < CW'(GRID_SIZE)) &&
                    (CW'(req_data.cell_y) < CW'(GRID_SIZE));
   assign keep    = (req_data.kind == gdr_pkg::KIND_CAST) || in_grid;

   assign req_ready = cmd_ready;
   assign cmd_push  = req_valid && cmd_ready && keep;

   assign cmd_data.is_cast   = (req_data.kind == gdr_pkg::KIND_CAST);
   assign cmd_data.column    = req_data.column;
   assign cmd_data.cell_x    = req_data.cell_x;
   assign cmd_data.cell_y    = req_data.cell_y;
   assign cmd_data.cell_wall = req_data.cell_wall;

endmodule

### design/gdr_engine.sv
// back end: map store, ray setup, dda walk, distance and span
module gdr_engine #(
   parameter int GRID_SIZE  = gdr_pkg::GRID_SIZE_DEF,
   parameter int STEP_LIMIT = gdr_pkg::STEP_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  gdr_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  gdr_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gdr_pkg::rsp_type rsp_data
);

   localparam int CW        = gdr_pkg::COORD_W;
   localparam int MEM_W     = (GRID_SIZE < (1 << gdr_pkg::CELL_W)) ?
                              GRID_SIZE : (1 << gdr_pkg::CELL_W);
   localparam int MEM_DEPTH = MEM_W * MEM_W;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(STEP_LIMIT + 1);
   localparam int RW        = gdr_pkg::RAY_W;
   localparam int PW        = gdr_pkg::PROD_W;
   localparam int NW        = gdr_pkg::NUM_W;
   localparam int SW        = gdr_pkg::SIDE_W;
   localparam int FW        = gdr_pkg::FRAC_W;

   localparam logic signed [CW-1:0] GRID_C   = CW'(GRID_SIZE);
   localparam logic signed [CW-1:0] MEM_W_C  = CW'(MEM_W);
   localparam logic signed [PW-1:0] RAY_HI   = PW'(131071);
   localparam logic signed [PW-1:0] RAY_LO   = -PW'(131072);
   localparam logic [gdr_pkg::DIV_NUM_W-1:0] DELTA_NUM = 32'h4000_0000;
   localparam logic [FW:0]          ONE_CELL = 13'd4096;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CX, ST_RAY_MUL, ST_RAY_SUM, ST_DX, ST_DY, ST_SIDE,
      ST_WALK, ST_TEST, ST_NUM, ST_DIST, ST_HGT_GO, ST_HGT, ST_SPAN
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
      cell_addr = AW'(y * CW'(MEM_W) + x);
   endfunction

   function automatic logic signed [RW-1:0] sat_ray(input logic signed [PW-1:0] v);
      if (v > RAY_HI) begin
         sat_ray = RW'(RAY_HI);
      end else if (v < RAY_LO) begin
         sat_ray = RW'(RAY_LO);
      end else begin
         sat_ray = v[RW-1:0];
      end
   endfunction

   state_type                          state_ff, state_in;
   logic signed [gdr_pkg::CX_W-1:0]    cx_ff, cx_in;
   logic signed [PW-1:0]               prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [RW-1:0]               rx_ff, rx_in, ry_ff, ry_in;
   logic [gdr_pkg::DELTA_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [SW-1:0]                      sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CW-1:0]               mx_ff, mx_in, my_ff, my_in;
   logic                               negx_ff, negx_in, negy_ff, negy_in;
   logic                               zx_ff, zx_in, zy_ff, zy_in;
   logic                               side_ff, side_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [AW-1:0]                      addr_ff, addr_in;
   logic                               oob_ff, oob_in, inmem_ff, inmem_in;
   logic                               rz_ff, rz_in;
   logic [gdr_pkg::DIST_W-1:0]         dist_ff, dist_in;
   logic [gdr_pkg::HGT_W-1:0]          height_ff, height_in;
   logic                               out_valid_ff, out_valid_in;
   gdr_pkg::rsp_type                   out_ff, out_in;
   logic                               valid_ff [MEM_DEPTH];
   logic                               valid_in [MEM_DEPTH];

   gdr_pkg::div_req_type div_req;
   gdr_pkg::div_rsp_type div_rsp;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [0:0]           ram_rdata;

   logic [gdr_pkg::COL_W-1:0] cols_eff;
   logic [gdr_pkg::ROW_W-1:0] rows_eff;

   assign cols_eff = (cfg.screen_cols == '0) ? gdr_pkg::COL_W'(1) : cfg.screen_cols;
   assign rows_eff = (cfg.screen_rows == '0) ? gdr_pkg::ROW_W'(1) : cfg.screen_rows;

   gdr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gdr_ram #(
      .WIDTH (1),
      .DEPTH (MEM_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.cell_wall),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      logic signed [PW-1:0]     sumx, sumy;
      logic [RW-1:0]            absx, absy, ar;
      logic [FW:0]              fracx, fracy;
      logic [FW+gdr_pkg::DELTA_W:0] px, py;
      logic                     take_x, hit;
      logic signed [CW-1:0]     mx_n, my_n, base;
      logic [FW-1:0]            fpos;
      logic [gdr_pkg::POS_W-1:0] pos;
      logic signed [RW-1:0]     ray;
      logic signed [NW-1:0]     num;
      logic [NW-1:0]            an;
      logic [gdr_pkg::DIST_W-1:0] d;
      logic [gdr_pkg::ROW_W-1:0]  half_r;
      logic [gdr_pkg::HGT_W-1:0]  half_h;
      logic [gdr_pkg::HGT_W:0]    sum_b;

      state_in     = state_ff;
      cx_in        = cx_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      side_in      = side_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      oob_in       = oob_ff;
      inmem_in     = inmem_ff;
      rz_in        = rz_ff;
      dist_in      = dist_ff;
      height_in    = height_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      valid_in     = valid_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(CW'(cmd_data.cell_x), CW'(cmd_data.cell_y));
      ram_raddr    = addr_ff;
      div_req      = '0;

      sumx   = PW'(cfg.view_dir_x) + (prodx_ff >>> gdr_pkg::VEC_FRAC_W);
      sumy   = PW'(cfg.view_dir_y) + (prody_ff >>> gdr_pkg::VEC_FRAC_W);
      absx   = '0;
      absy   = ry_ff[RW-1] ? RW'(-ry_ff) : RW'(ry_ff);
      fracx  = negx_ff ? {1'b0, cfg.cam_pos_x[FW-1:0]}
                       : ONE_CELL - {1'b0, cfg.cam_pos_x[FW-1:0]};
      fracy  = negy_ff ? {1'b0, cfg.cam_pos_y[FW-1:0]}
                       : ONE_CELL - {1'b0, cfg.cam_pos_y[FW-1:0]};
      px     = (FW + gdr_pkg::DELTA_W + 1)'(fracx) * (FW + gdr_pkg::DELTA_W + 1)'(dx_ff);
      py     = (FW + gdr_pkg::DELTA_W + 1)'(fracy) * (FW + gdr_pkg::DELTA_W + 1)'(dy_ff);

      // dda step: ties to y; a zero part steps only if both are
      take_x = !zx_ff && (zy_ff || (sx_ff < sy_ff));
      mx_n   = mx_ff;
      my_n   = my_ff;
      if (take_x) begin
         mx_n = negx_ff ? mx_ff - CW'(1) : mx_ff + CW'(1);
      end else begin
         my_n = negy_ff ? my_ff - CW'(1) : my_ff + CW'(1);
      end

      hit = oob_ff || (inmem_ff && valid_ff[addr_ff] && ram_rdata[0]);

      // struck grid line and ray component for the hit side
      if (side_ff == gdr_pkg::SIDE_X) begin
         base = mx_ff + (negx_ff ? CW'(1) : CW'(0));
         pos  = cfg.cam_pos_x;
         ray  = rx_ff;
      end else begin
         base = my_ff + (negy_ff ? CW'(1) : CW'(0));
         pos  = cfg.cam_pos_y;
         ray  = ry_ff;
      end
      fpos = '0;
      num  = $signed({{(NW-CW-FW){base[CW-1]}}, base, fpos})
             - $signed({{(NW-gdr_pkg::POS_W){1'b0}}, pos});
      an   = num[NW-1] ? NW'(-num) : NW'(num);
      ar   = ray[RW-1] ? RW'(-ray) : RW'(ray);

      d = (div_rsp.quo[gdr_pkg::DIV_NUM_W-1:gdr_pkg::DIST_W] != '0) ? '1
                                                                     : div_rsp.quo[gdr_pkg::DIST_W-1:0];
      if (rz_ff) begin
         d = '1;
      end
      if (d == '0) begin
         d = gdr_pkg::DIST_W'(1);
      end

      half_r = rows_eff >> 1;
      half_h = height_ff >> 1;
      sum_b  = (gdr_pkg::HGT_W + 1)'(half_r) + (gdr_pkg::HGT_W + 1)'(half_h);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_data.is_cast) begin
                  div_req.start = 1'b1;
                  div_req.num   = gdr_pkg::DIV_NUM_W'({cmd_data.column, 15'd0});
                  div_req.den   = gdr_pkg::DIV_DEN_W'(cols_eff);
                  state_in      = ST_CX;
               end else begin
                  ram_we               = 1'b1;
                  valid_in[ram_waddr] = 1'b1;
               end
            end
         end
         ST_CX: begin
            if (div_rsp.done) begin
               cx_in    = $signed({1'b0, div_rsp.quo[gdr_pkg::CX_W-2:0]})
                          - $signed(gdr_pkg::CX_W'(16384));
               state_in = ST_RAY_MUL;
            end
         end
         ST_RAY_MUL: begin
            prodx_in = PW'(cfg.cam_plane_x) * PW'(cx_ff);
            prody_in = PW'(cfg.cam_plane_y) * PW'(cx_ff);
            state_in = ST_RAY_SUM;
         end
         ST_RAY_SUM: begin
            rx_in   = sat_ray(sumx);
            ry_in   = sat_ray(sumy);
            absx    = rx_in[RW-1] ? RW'(-rx_in) : RW'(rx_in);
            negx_in = rx_in[RW-1];
            negy_in = ry_in[RW-1];
            zx_in   = (rx_in == '0);
            zy_in   = (ry_in == '0);
            div_req.start = 1'b1;
            div_req.num   = DELTA_NUM;
            div_req.den   = zx_in ? gdr_pkg::DIV_DEN_W'(1) : gdr_pkg::DIV_DEN_W'(absx);
            state_in      = ST_DX;
         end
         ST_DX: begin
            if (div_rsp.done) begin
               dx_in         = div_rsp.quo[gdr_pkg::DELTA_W-1:0];
               div_req.start = 1'b1;
               div_req.num   = DELTA_NUM;
               div_req.den   = zy_ff ? gdr_pkg::DIV_DEN_W'(1) : gdr_pkg::DIV_DEN_W'(absy);
               state_in      = ST_DY;
            end
         end
         ST_DY: begin
            if (div_rsp.done) begin
               dy_in    = div_rsp.quo[gdr_pkg::DELTA_W-1:0];
               state_in = ST_SIDE;
            end
         end
         ST_SIDE: begin
            sx_in    = SW'(px >> FW);
            sy_in    = SW'(py >> FW);
            mx_in    = CW'(cfg.cam_pos_x[gdr_pkg::POS_W-1:FW]);
            my_in    = CW'(cfg.cam_pos_y[gdr_pkg::POS_W-1:FW]);
            cnt_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (take_x) begin
               sx_in   = sx_ff + SW'(dx_ff);
               side_in = gdr_pkg::SIDE_X;
            end else begin
               sy_in   = sy_ff + SW'(dy_ff);
               side_in = gdr_pkg::SIDE_Y;
            end
            mx_in     = mx_n;
            my_in     = my_n;
            cnt_in    = cnt_ff + CNT_W'(1);
            oob_in    = mx_n[CW-1] || my_n[CW-1] || (mx_n >= GRID_C) || (my_n >= GRID_C);
            inmem_in  = !mx_n[CW-1] && !my_n[CW-1] && (mx_n < MEM_W_C) && (my_n < MEM_W_C);
            addr_in   = cell_addr(mx_n, my_n);
            ram_raddr = addr_in;
            state_in  = ST_TEST;
         end
         ST_TEST: begin
            if (hit || (cnt_ff == CNT_W'(STEP_LIMIT))) begin
               state_in = ST_NUM;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_NUM: begin
            rz_in         = (ray == '0);
            div_req.start = 1'b1;
            div_req.num   = gdr_pkg::DIV_NUM_W'({an, 10'd0});
            div_req.den   = (ray == '0) ? gdr_pkg::DIV_DEN_W'(1) : gdr_pkg::DIV_DEN_W'(ar);
            state_in      = ST_DIST;
         end
         ST_DIST: begin
            if (div_rsp.done) begin
               dist_in  = d;
               state_in = ST_HGT_GO;
            end
         end
         ST_HGT_GO: begin
            div_req.start = 1'b1;
            div_req.num   = gdr_pkg::DIV_NUM_W'({rows_eff, 8'd0});
            div_req.den   = gdr_pkg::DIV_DEN_W'(dist_ff);
            state_in      = ST_HGT;
         end
         ST_HGT: begin
            if (div_rsp.done) begin
               height_in = div_rsp.quo[gdr_pkg::HGT_W-1:0];
               state_in  = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in.span_top      = (half_h > gdr_pkg::HGT_W'(half_r)) ? '0 :
                                      gdr_pkg::ROW_W'(gdr_pkg::HGT_W'(half_r) - half_h);
               out_in.span_bottom   = (sum_b >= (gdr_pkg::HGT_W + 1)'(rows_eff)) ?
                                      rows_eff - gdr_pkg::ROW_W'(1) :
                                      sum_b[gdr_pkg::ROW_W-1:0];
               out_in.hit_side      = side_ff;
               out_in.hit_cell_x    = mx_ff[gdr_pkg::CELL_W-1:0];
               out_in.hit_cell_y    = my_ff[gdr_pkg::CELL_W-1:0];
               out_in.wall_distance = dist_ff;
               out_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MEM_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      prodx_ff  <= prodx_in;
      prody_ff  <= prody_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      zx_ff     <= zx_in;
      zy_ff     <= zy_in;
      side_ff   <= side_in;
      cnt_ff    <= cnt_in;
      addr_ff   <= addr_in;
      oob_ff    <= oob_in;
      inmem_ff  <= inmem_in;
      rz_ff     <= rz_in;
      dist_ff   <= dist_in;
      height_ff <= height_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### design/grid_dda_column_raycaster.sv
// top level of the grid dda column raycaster
// Casts one ray per screen column through a wall grid and returns the
// clamped vertical wall span, hit side, hit cell and perpendicular distance
// (Q8.8). A cast item gives one result transfer; a cell write item gives
// none and updates the map, which is empty after reset. A front end takes
// a req transfer whenever the two-entry command queue has room and drops
// cell writes outside the grid; the back end runs one item at a time. A
// cell write is done in the idle state. A cast walks at most STEP_LIMIT
// grid steps. Its five divides share one divider that resolves 4 quotient
// bits per cycle, and each walk step waits for the registered read of the
// map memory. The result sits in an output register, so the back end
// starts the next item while it waits for rsp_ready. Camera registers are
// written through the csr port, always ready; the user must write them
// only while no item is in flight, which the block itself does not enforce.
module grid_dda_column_raycaster #(
   parameter int GRID_SIZE  = gdr_pkg::GRID_SIZE_DEF,
   parameter int STEP_LIMIT = gdr_pkg::STEP_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gdr_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gdr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gdr_pkg::CSR_DATA_W-1:0]     csr_data
);

   gdr_pkg::cfg_type cfg_ff, cfg_in;
   logic             cmd_push, cmd_ready, cmd_pop, cmd_valid;
   gdr_pkg::cmd_type cmd_in_data, cmd_out_data;

   // csr writes are registered straight into the camera registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (gdr_pkg::csr_index_type'(csr_index))
            gdr_pkg::CSR_CAM_POS_X:   cfg_in.cam_pos_x   = csr_data;
            gdr_pkg::CSR_CAM_POS_Y:   cfg_in.cam_pos_y   = csr_data;
            gdr_pkg::CSR_VIEW_DIR_X:  cfg_in.view_dir_x  = $signed(csr_data);
            gdr_pkg::CSR_VIEW_DIR_Y:  cfg_in.view_dir_y  = $signed(csr_data);
            gdr_pkg::CSR_CAM_PLANE_X: cfg_in.cam_plane_x = $signed(csr_data);
            gdr_pkg::CSR_CAM_PLANE_Y: cfg_in.cam_plane_y = $signed(csr_data);
            gdr_pkg::CSR_SCREEN_COLS: cfg_in.screen_cols = csr_data[gdr_pkg::COL_W-1:0];
            gdr_pkg::CSR_SCREEN_ROWS: cfg_in.screen_rows = csr_data[gdr_pkg::ROW_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_pos_x   <= gdr_pkg::CAM_POS_X_RST;
         cfg_ff.cam_pos_y   <= gdr_pkg::CAM_POS_Y_RST;
         cfg_ff.view_dir_x  <= gdr_pkg::VIEW_DIR_X_RST;
         cfg_ff.view_dir_y  <= gdr_pkg::VIEW_DIR_Y_RST;
         cfg_ff.cam_plane_x <= gdr_pkg::CAM_PLANE_X_RST;
         cfg_ff.cam_plane_y <= gdr_pkg::CAM_PLANE_Y_RST;
         cfg_ff.screen_cols <= gdr_pkg::SCREEN_COLS_RST;
         cfg_ff.screen_rows <= gdr_pkg::SCREEN_ROWS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and filter
   gdr_front #(
      .GRID_SIZE (GRID_SIZE)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data),
      .cmd_ready (cmd_ready)
   );

   // decoupling queue
   gdr_queue #(
      .DEPTH (gdr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in_data),
      .push_ready (cmd_ready),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_out_data)
   );

   // back end: map, ray setup, walk and span
   gdr_engine #(
      .GRID_SIZE  (GRID_SIZE),
      .STEP_LIMIT (STEP_LIMIT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/gdr_checker.sv
// transfer monitor, column cast predictor and result comparator
`timescale 1ns / 1ps
module gdr_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  gdr_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  gdr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [gdr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gdr_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                fail_count,
   output int                                pending
);

   localparam int GRID  = gdr_pkg::GRID_SIZE_DEF;
   localparam int STEPS = gdr_pkg::STEP_LIMIT_DEF;
   localparam int FW    = gdr_pkg::FRAC_W;

   logic [gdr_pkg::POS_W-1:0]        pos_x, pos_y;
   logic signed [gdr_pkg::VEC_W-1:0] dir_x, dir_y, pl_x, pl_y;
   logic [gdr_pkg::COL_W-1:0]        cols_r;
   logic [gdr_pkg::ROW_W-1:0]        rows_r;
   bit                               wall_bits [0:GRID*GRID-1];
   gdr_pkg::rsp_type                 expected_spans [$];

   function automatic longint floor_quot(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip_ray(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic bit blocked(int x, int y);
      if (x < 0 || y < 0 || x >= GRID || y >= GRID) return 1'b1;
      return wall_bits[y*GRID + x];
   endfunction

   function automatic gdr_pkg::rsp_type trace_column(logic [gdr_pkg::COL_W-1:0] col);
      gdr_pkg::rsp_type r;
      longint cols, rows, cx, rx, ry, dx, dy, sx, sy, fx, fy;
      longint num, rside, an, ar, wall_dist, height, top, bottom;
      int mx, my, stx, sty, side, i;
      bit zx, zy;
      cols = (cols_r == 0) ? 1 : longint'(cols_r);
      rows = (rows_r == 0) ? 1 : longint'(rows_r);
      cx = (longint'(col) * 2 * 16384) / cols - 16384;
      rx = clip_ray(longint'(dir_x) + floor_quot(longint'(pl_x) * cx, 16384));
      ry = clip_ray(longint'(dir_y) + floor_quot(longint'(pl_y) * cx, 16384));
      zx = (rx == 0);
      zy = (ry == 0);
      mx = int'(pos_x >> FW);
      my = int'(pos_y >> FW);
      fx = longint'(pos_x[FW-1:0]);
      fy = longint'(pos_y[FW-1:0]);
      dx = zx ? 0 : (64'd1 << 30) / (rx < 0 ? -rx : rx);
      dy = zy ? 0 : (64'd1 << 30) / (ry < 0 ? -ry : ry);
      if (rx < 0) begin stx = -1; sx = (fx * dx) >> 12; end
      else begin stx = 1; sx = ((4096 - fx) * dx) >> 12; end
      if (ry < 0) begin sty = -1; sy = (fy * dy) >> 12; end
      else begin sty = 1; sy = ((4096 - fy) * dy) >> 12; end
      side = 0;
      for (i = 0; i < STEPS; i++) begin
         if (!zx && (zy || sx < sy)) begin
            sx += dx; mx += stx; side = 0;
         end else begin
            sy += dy; my += sty; side = 1;
         end
         if (blocked(mx, my)) break;
      end
      // offset from camera to the grid line that was crossed
      if (side == 0) begin
         num = longint'(mx + (stx < 0 ? 1 : 0)) * 4096 - longint'(pos_x);
         rside = rx;
      end else begin
         num = longint'(my + (sty < 0 ? 1 : 0)) * 4096 - longint'(pos_y);
         rside = ry;
      end
      if (rside == 0) wall_dist = 65535;
      else begin
         an = (num < 0) ? -num : num;
         ar = (rside < 0) ? -rside : rside;
         wall_dist = (an * 1024) / ar;
         if (wall_dist > 65535) wall_dist = 65535;
      end
      if (wall_dist == 0) wall_dist = 1;
      height = (rows * 256) / wall_dist;
      top = rows / 2 - height / 2;
      bottom = rows / 2 + height / 2;
      if (top < 0) top = 0;
      if (bottom >= rows) bottom = rows - 1;
      r.span_top      = top[gdr_pkg::ROW_W-1:0];
      r.span_bottom   = bottom[gdr_pkg::ROW_W-1:0];
      r.hit_side      = (side == 0) ? gdr_pkg::SIDE_X : gdr_pkg::SIDE_Y;
      r.hit_cell_x    = mx[gdr_pkg::CELL_W-1:0];
      r.hit_cell_y    = my[gdr_pkg::CELL_W-1:0];
      r.wall_distance = wall_dist[gdr_pkg::DIST_W-1:0];
      return r;
   endfunction

   task automatic log_miss(string what, gdr_pkg::rsp_type want, gdr_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t mismatch (%s): expected top %0d bot %0d side %0d cell %0d,%0d dist %0d",
            $time, what, want.span_top, want.span_bottom, want.hit_side, want.hit_cell_x,
            want.hit_cell_y, want.wall_distance);
         $display("   got top %0d bot %0d side %0d cell %0d,%0d dist %0d",
            got.span_top, got.span_bottom, got.hit_side, got.hit_cell_x,
            got.hit_cell_y, got.wall_distance);
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      gdr_pkg::rsp_type want;
      if (reset) begin
         pos_x = gdr_pkg::CAM_POS_X_RST;     pos_y = gdr_pkg::CAM_POS_Y_RST;
         dir_x = gdr_pkg::VIEW_DIR_X_RST;    dir_y = gdr_pkg::VIEW_DIR_Y_RST;
         pl_x = gdr_pkg::CAM_PLANE_X_RST;    pl_y = gdr_pkg::CAM_PLANE_Y_RST;
         cols_r = gdr_pkg::SCREEN_COLS_RST;  rows_r = gdr_pkg::SCREEN_ROWS_RST;
         foreach (wall_bits[k]) wall_bits[k] = 1'b0;
         expected_spans.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (gdr_pkg::csr_index_type'(csr_index))
               gdr_pkg::CSR_CAM_POS_X:   pos_x = csr_data;
               gdr_pkg::CSR_CAM_POS_Y:   pos_y = csr_data;
               gdr_pkg::CSR_VIEW_DIR_X:  dir_x = csr_data;
               gdr_pkg::CSR_VIEW_DIR_Y:  dir_y = csr_data;
               gdr_pkg::CSR_CAM_PLANE_X: pl_x = csr_data;
               gdr_pkg::CSR_CAM_PLANE_Y: pl_y = csr_data;
               gdr_pkg::CSR_SCREEN_COLS: cols_r = csr_data[gdr_pkg::COL_W-1:0];
               gdr_pkg::CSR_SCREEN_ROWS: rows_r = csr_data[gdr_pkg::ROW_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == gdr_pkg::KIND_CAST)
               expected_spans.push_back(trace_column(req_data.column));
            else
               wall_bits[{req_data.cell_y, req_data.cell_x}] = req_data.cell_wall;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               want = '0;
               log_miss("unexpected", want, rsp_data);
            end else begin
               want = expected_spans.pop_front();
               if (want !== rsp_data) log_miss("field", want, rsp_data);
            end
         end
      end
      pending = expected_spans.size();
   end

endmodule

### sim/tb_top.sv
// stimulus, clock, reset and verdict for the grid dda column raycaster
`timescale 1ns / 1ps
module tb_top;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 200;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   gdr_pkg::req_type                 req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   gdr_pkg::rsp_type                 rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [gdr_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [gdr_pkg::CSR_DATA_W-1:0]   csr_data = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   grid_dda_column_raycaster u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   gdr_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern, changed per phase
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ((cycles % 11) > 6);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // one req transfer; idle gaps only between bursts, gap is never zero
   task automatic send_req(gdr_pkg::req_type it);
      if (burst_left == 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic cast(int col);
      gdr_pkg::req_type it;
      it = ($bits(gdr_pkg::req_type))'($urandom);
      it.kind = gdr_pkg::KIND_CAST;
      it.column = col[gdr_pkg::COL_W-1:0];
      send_req(it);
   endtask

   task automatic put_cell(int x, int y, bit wall);
      gdr_pkg::req_type it;
      it = ($bits(gdr_pkg::req_type))'($urandom);
      it.kind = gdr_pkg::KIND_CELL_WRITE;
      it.cell_x = x[gdr_pkg::CELL_W-1:0];
      it.cell_y = y[gdr_pkg::CELL_W-1:0];
      it.cell_wall = wall;
      send_req(it);
   endtask

   // wait for every result, then let trailing cell writes finish
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write all registers in one back-to-back burst while the block is idle
   task automatic load_camera(gdr_pkg::cfg_type c);
      logic [gdr_pkg::CSR_DATA_W-1:0] vals [0:7];
      vals[gdr_pkg::CSR_CAM_POS_X]   = c.cam_pos_x;
      vals[gdr_pkg::CSR_CAM_POS_Y]   = c.cam_pos_y;
      vals[gdr_pkg::CSR_VIEW_DIR_X]  = c.view_dir_x;
      vals[gdr_pkg::CSR_VIEW_DIR_Y]  = c.view_dir_y;
      vals[gdr_pkg::CSR_CAM_PLANE_X] = c.cam_plane_x;
      vals[gdr_pkg::CSR_CAM_PLANE_Y] = c.cam_plane_y;
      vals[gdr_pkg::CSR_SCREEN_COLS] = gdr_pkg::CSR_DATA_W'(c.screen_cols);
      vals[gdr_pkg::CSR_SCREEN_ROWS] = gdr_pkg::CSR_DATA_W'(c.screen_rows);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= gdr_pkg::CSR_INDEX_W'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic gdr_pkg::cfg_type camera(int px, int py, int vx, int vy, int qx,
                                               int qy, int nc, int nr);
      gdr_pkg::cfg_type c;
      c.cam_pos_x = px[15:0];   c.cam_pos_y = py[15:0];
      c.view_dir_x = vx[15:0];  c.view_dir_y = vy[15:0];
      c.cam_plane_x = qx[15:0]; c.cam_plane_y = qy[15:0];
      c.screen_cols = nc[11:0]; c.screen_rows = nr[11:0];
      return c;
   endfunction

   function automatic int pick_vec();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 7))
         0: return 4095;
         1: return $urandom_range(0, 1);
         default: return $urandom_range(2, 1200);
      endcase
   endfunction

   initial begin
      gdr_pkg::cfg_type c;
      int nc;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset camera sits exactly on a grid corner
      stall_mode = 0;
      cast(0); cast(799); cast(4095); cast(400);
      put_cell(0, 0, 1); put_cell(15, 15, 1); put_cell(3, 5, 1);
      cast(400); put_cell(3, 5, 0); cast(400);
      drain();
      // both ray components zero: walk goes +y
      load_camera(camera(20480, 20480, 0, 0, 0, 0, 800, 600));
      cast(0); cast(400);
      drain();
      // x component zero only, step tie on the diagonal
      load_camera(camera(22528, 22528, 0, 16384, 0, 0, 800, 600));
      cast(10);
      drain();
      load_camera(camera(22528, 22528, 16384, 16384, 0, 0, 800, 600));
      cast(10); cast(799);
      drain();
      // zero screen size, then the extremes
      load_camera(camera(2048, 63488, 10000, -10000, 3000, 3000, 0, 0));
      cast(0); cast(4095);
      drain();
      load_camera(camera(65535, 0, -32768, 32767, 32767, -32768, 4095, 4095));
      cast(0); cast(2047); cast(4095);
      drain();
      load_camera(camera(0, 65535, 32767, -32768, -32768, 32767, 1, 1));
      cast(0); cast(4095);
      drain();

      // random phases with random cameras and maps
      for (int ph = 0; ph < 10; ph++) begin
         stall_mode = ph % 4;
         c = camera($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(4096, 61439),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(4096, 61439),
                    pick_vec(), pick_vec(), pick_vec(), pick_vec(),
                    pick_size(), pick_size());
         load_camera(c);
         nc = (c.screen_cols == 0) ? 1 : int'(c.screen_cols);
         for (int n = 0; n < 183; n++) begin
            if ($urandom_range(0, 3) == 0)
               put_cell($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 9) < 3);
            else if ($urandom_range(0, 4) == 0)
               cast($urandom_range(0, 4095));
            else
               cast($urandom_range(0, nc - 1));
         end
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
design/gdr_pkg.sv
design/gdr_ram.sv
design/gdr_div.sv
design/gdr_queue.sv
design/gdr_front.sv
design/gdr_engine.sv
design/grid_dda_column_raycaster.sv
sim/gdr_checker.sv
sim/tb_top.sv
